/* hdl/http_request_header_tokenizer_assert.svh */
// assertion macros shared by the tokenizer modules
// no dependencies; included by the modules that check their own logic
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define HRT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");
// next-cycle implication, disabled in reset
`define HRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define HRT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define HRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/hrt_pkg.sv */
// types, constants and helpers for the http request header tokenizer
// no dependencies; imported by every tokenizer module
package hrt_pkg;

    // length arithmetic width and configuration width
    localparam int LENGTH_BITS = 32;
    localparam int CFG_W       = 32;
    localparam int CMP_W       = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
    localparam logic [CFG_W-1:0] MAX_BODY_RESET = CFG_W'(65536);

    // header name matched for the body length
    localparam int NAME_LEN = 14;
    localparam int POS_W    = $clog2(NAME_LEN + 1);

    // delimiter characters
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_VERSION = 3'd2,
        PH_KEY     = 3'd3,
        PH_VALUE   = 3'd4,
        PH_BODY    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_METHOD    = 3'd0,
        KIND_URL       = 3'd1,
        KIND_VERSION   = 3'd2,
        KIND_KEY       = 3'd3,
        KIND_VALUE     = 3'd4,
        KIND_BODY      = 3'd5,
        KIND_DELIM     = 3'd6,
        KIND_BODY_DROP = 3'd7
    } t_kind;

    // one classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       msg_start;
        logic       is_space;
        logic       is_cr;
        logic       is_colon;
        logic       is_digit;
        logic [3:0] digit;
    } t_tok;

    // characters of "Content-Length" by position
    function automatic logic [7:0] name_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            POS_W'(0):  c = 8'h43; // C
            POS_W'(1):  c = 8'h6F; // o
            POS_W'(2):  c = 8'h6E; // n
            POS_W'(3):  c = 8'h74; // t
            POS_W'(4):  c = 8'h65; // e
            POS_W'(5):  c = 8'h6E; // n
            POS_W'(6):  c = 8'h74; // t
            POS_W'(7):  c = 8'h2D; // -
            POS_W'(8):  c = 8'h4C; // L
            POS_W'(9):  c = 8'h65; // e
            POS_W'(10): c = 8'h6E; // n
            POS_W'(11): c = 8'h67; // g
            POS_W'(12): c = 8'h74; // t
            POS_W'(13): c = 8'h68; // h
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hdl/hrt_front.sv */
// front end: input handshake and byte classification into queue tokens
// depends on hrt_pkg
module hrt_front (
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_byte_in,
    input  logic          i_message_start,
    input  logic          i_q_full,
    output logic          o_push,
    output hrt_pkg::t_tok o_tok
);
    import hrt_pkg::*;

    // stall whenever the queue has no room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // classify the byte once so the back end only sees flags
    always_comb begin
        o_tok.data      = i_byte_in;
        o_tok.msg_start = i_message_start;
        o_tok.is_space  = (i_byte_in == CHAR_SPACE);
        o_tok.is_cr     = (i_byte_in == CHAR_CR);
        o_tok.is_colon  = (i_byte_in == CHAR_COLON);
        o_tok.is_digit  = (i_byte_in >= CHAR_ZERO) && (i_byte_in <= CHAR_NINE);
        o_tok.digit     = 4'(i_byte_in - CHAR_ZERO);
    end

endmodule

/* hdl/hrt_queue.sv */
// short token queue decoupling the classifier from the parser
// depends on hrt_pkg and the assertion header
`include "http_request_header_tokenizer_assert.svh"
module hrt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hrt_pkg::t_tok i_tok,
    input  logic          i_pop,
    output hrt_pkg::t_tok o_tok,
    output logic          o_full,
    output logic          o_not_empty
);
    import hrt_pkg::*;

    t_tok            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_full      = (r_count == Q_CW'(Q_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_tok       = r_mem[r_rd_ptr];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= Q_AW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= Q_AW'(r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= Q_CW'(r_count + 1'b1);
                2'b01:   r_count <= Q_CW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    // queue sanity
    `HRT_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, r_count != Q_CW'(Q_DEPTH))
    `HRT_ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `HRT_ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= Q_CW'(Q_DEPTH))

endmodule

/* hdl/hrt_back.sv */
// back end: request phase tracking, length accumulation and result register
// depends on hrt_pkg and the assertion header
`include "http_request_header_tokenizer_assert.svh"
module hrt_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [hrt_pkg::CFG_W-1:0] i_cfg_max_body_bytes,
    input  hrt_pkg::t_tok            i_tok,
    input  logic                     i_not_empty,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [7:0]               o_byte_out,
    output logic [2:0]               o_byte_kind,
    output logic                     o_header_done,
    output logic [31:0]              o_declared_len,
    output logic                     o_body_complete,
    output logic                     o_body_too_large
);
    import hrt_pkg::*;

    localparam int LB = LENGTH_BITS;

    // configuration
    logic [CFG_W-1:0] r_max;

    // parser state
    t_phase           r_phase,  n_phase;
    logic             r_skip,   n_skip;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic             r_still,  n_still;
    logic             r_islen,  n_islen;
    logic [LB-1:0]    r_acc,    n_acc;
    logic             r_open,   n_open;
    logic [LB-1:0]    r_decl,   n_decl;
    logic [LB-1:0]    r_cnt,    n_cnt;

    // result register
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    t_kind            r_okind;
    logic             r_odone;
    logic [31:0]      r_olen;
    logic             r_ocomplete;
    logic             r_otoo;

    t_kind            n_kind;
    logic             n_done;
    logic             n_too;
    logic             body_big;
    logic [LB+3:0]    wide;

    assign o_cfg_ready = 1'b1;

    // take a token whenever the result register is free or drains
    assign o_pop = i_not_empty && (!r_ovalid || !i_stall);

    // declared length against the limit, as held before this byte
    assign body_big = (CMP_W'(r_decl) > CMP_W'(r_max));

    // next state and result for the token at the queue head
    always_comb begin
        n_phase = r_phase;
        n_skip  = r_skip;
        n_pos   = r_pos;
        n_still = r_still;
        n_islen = r_islen;
        n_acc   = r_acc;
        n_open  = r_open;
        n_decl  = r_decl;
        n_cnt   = r_cnt;
        n_kind  = KIND_DELIM;
        n_done  = 1'b0;
        wide    = '0;

        // new request clears everything but the limit
        if (i_tok.msg_start) begin
            n_phase = PH_METHOD;
            n_skip  = 1'b0;
            n_pos   = '0;
            n_still = 1'b1;
            n_islen = 1'b0;
            n_acc   = '0;
            n_open  = 1'b1;
            n_decl  = '0;
            n_cnt   = '0;
        end

        if (n_skip) begin
            n_skip = 1'b0;
        end else begin
            unique case (n_phase)
                PH_METHOD: begin
                    if (i_tok.is_space) n_phase = PH_URL;
                    else n_kind = KIND_METHOD;
                end
                PH_URL: begin
                    if (i_tok.is_space) n_phase = PH_VERSION;
                    else n_kind = KIND_URL;
                end
                PH_VERSION: begin
                    if (i_tok.is_cr) begin
                        n_phase = PH_KEY;
                        n_skip  = 1'b1;
                    end else begin
                        n_kind = KIND_VERSION;
                    end
                end
                PH_KEY: begin
                    if (i_tok.is_cr) begin
                        // blank line ends the header block
                        n_phase = PH_BODY;
                        n_skip  = 1'b1;
                        n_done  = 1'b1;
                        n_pos   = '0;
                        n_still = 1'b1;
                        n_islen = 1'b0;
                        n_acc   = '0;
                        n_open  = 1'b1;
                    end else if (i_tok.is_colon) begin
                        n_islen = n_still && (n_pos == POS_W'(NAME_LEN));
                        n_phase = PH_VALUE;
                        n_skip  = 1'b1;
                    end else begin
                        n_kind = KIND_KEY;
                        if (n_still && (n_pos < POS_W'(NAME_LEN)) &&
                            (i_tok.data == name_char(n_pos))) begin
                            n_pos = POS_W'(n_pos + 1'b1);
                        end else begin
                            n_still = 1'b0;
                        end
                    end
                end
                PH_VALUE: begin
                    if (i_tok.is_cr) begin
                        if (n_islen) n_decl = n_acc;
                        n_pos   = '0;
                        n_still = 1'b1;
                        n_islen = 1'b0;
                        n_acc   = '0;
                        n_open  = 1'b1;
                        n_phase = PH_KEY;
                        n_skip  = 1'b1;
                    end else begin
                        n_kind = KIND_VALUE;
                        if (n_islen && n_open) begin
                            if (i_tok.is_digit) begin
                                // times ten plus digit, saturating
                                wide = ((LB+4)'(n_acc) << 3) + ((LB+4)'(n_acc) << 1) +
                                       (LB+4)'(i_tok.digit);
                                n_acc = (|wide[LB+3:LB]) ? '1 : wide[LB-1:0];
                            end else begin
                                n_open = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    // body bytes counted up to the declared length, all dropped if it is over the limit
                    if (body_big) begin
                        n_kind = KIND_BODY_DROP;
                    end else if (n_cnt < n_decl) begin
                        n_cnt  = LB'(n_cnt + 1'b1);
                        n_kind = KIND_BODY;
                    end else begin
                        n_kind = KIND_BODY_DROP;
                    end
                end
            endcase
        end

        n_too = (CMP_W'(n_decl) > CMP_W'(r_max));
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_BODY_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_max_body_bytes;
        end
    end

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_skip  <= 1'b0;
            r_pos   <= '0;
            r_still <= 1'b1;
            r_islen <= 1'b0;
            r_acc   <= '0;
            r_open  <= 1'b1;
            r_decl  <= '0;
            r_cnt   <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_pos   <= n_pos;
            r_still <= n_still;
            r_islen <= n_islen;
            r_acc   <= n_acc;
            r_open  <= n_open;
            r_decl  <= n_decl;
            r_cnt   <= n_cnt;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_pop) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // result payload, length fields only live in the body phase
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_obyte     <= i_tok.data;
            r_okind     <= n_kind;
            r_odone     <= n_done;
            r_olen      <= (n_phase == PH_BODY) ? 32'(n_decl) : '0;
            r_ocomplete <= (n_phase == PH_BODY) && !n_too && (n_cnt == n_decl);
            r_otoo      <= (n_phase == PH_BODY) && n_too;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_byte_out       = r_obyte;
    assign o_byte_kind      = r_okind;
    assign o_header_done    = r_odone;
    assign o_declared_len   = r_olen;
    assign o_body_complete  = r_ocomplete;
    assign o_body_too_large = r_otoo;

    // parser consistency
    `HRT_ASSERT_IMPLIES(a_skip_phase, i_clk, i_rst_n, r_skip, r_phase >= PH_KEY)
    `HRT_ASSERT_IMPLIES(a_done_delim, i_clk, i_rst_n, r_ovalid && r_odone, r_okind == KIND_DELIM)
    `HRT_ASSERT_IMPLIES(a_complete_fits, i_clk, i_rst_n, r_ovalid && r_ocomplete, !r_otoo)
    `HRT_ASSERT_NEXT(a_pop_shows, i_clk, i_rst_n, o_pop, o_valid)

endmodule

/* hdl/http_request_header_tokenizer.sv */
// http request header tokenizer: one request byte in, one tagged byte out.
// an accepted byte is written into the token queue, then parsed into the result register.
// throughput: one byte per cycle while the output does not stall, set by the back-end parser step.
// a four-entry token queue lets input and output stall independently.
// reset (synchronous, active low) empties the queue, clears parser state, limit 65536.
// built from hrt_front, hrt_queue and hrt_back; depends on hrt_pkg
module http_request_header_tokenizer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_byte_in,
    input  logic                      i_message_start,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_byte_out,
    output logic [2:0]                o_byte_kind,
    output logic                      o_header_done,
    output logic [31:0]               o_declared_len,
    output logic                      o_body_complete,
    output logic                      o_body_too_large,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [hrt_pkg::CFG_W-1:0] i_cfg_max_body_bytes
);
    import hrt_pkg::*;

    t_tok front_tok;
    t_tok queue_tok;
    logic push;
    logic pop;
    logic q_full;
    logic q_not_empty;

    // classification and input handshake
    hrt_front u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_byte_in       (i_byte_in),
        .i_message_start (i_message_start),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_tok           (front_tok)
    );

    // decoupling queue
    hrt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_tok       (front_tok),
        .i_pop       (pop),
        .o_tok       (queue_tok),
        .o_full      (q_full),
        .o_not_empty (q_not_empty)
    );

    // parser and result register
    hrt_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_max_body_bytes (i_cfg_max_body_bytes),
        .i_tok                (queue_tok),
        .i_not_empty          (q_not_empty),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_byte_out           (o_byte_out),
        .o_byte_kind          (o_byte_kind),
        .o_header_done        (o_header_done),
        .o_declared_len       (o_declared_len),
        .o_body_complete      (o_body_complete),
        .o_body_too_large     (o_body_too_large)
    );

endmodule
